// ----- hw/rtl/rmp_pkg.sv -----
`timescale 1ns / 1ps
package rmp_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CODEC_KIND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAMING_ON = 1'b1;

  typedef enum logic [1:0] {
    CODEC_SBC  = 2'd0,
    CODEC_AAC  = 2'd1,
    CODEC_LC3  = 2'd2,
    CODEC_APTX = 2'd3
  } codec_t;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_STREAMING = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [31:0] TS_INCR_SBC = 32'd128;
  localparam logic [31:0] TS_INCR_AAC = 32'd1024;
  localparam logic [31:0] TS_INCR_LC3 = 32'd480;

  localparam logic [7:0] RTP_BYTE0 = 8'h80;
  localparam logic [7:0] RTP_BYTE1 = 8'h60;
  localparam logic [31:0] RTP_SSRC = 32'h0000_0001;
  localparam logic [7:0] MEDIA_HDR_BYTE = 8'h01;

  localparam logic [16:0] MAX_PACKET_LEN = 17'h0FFFF;
  localparam logic [16:0] HLEN_RTP_PAY = 17'd13;
  localparam logic [16:0] HLEN_RTP = 17'd12;

  localparam int HDR_IDX_W = 4;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_RTP = 4'd11;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_PAY = 4'd12;

  localparam int RMP_FIFO_DEPTH = 4;

  typedef enum logic {
    ENT_ONE = 1'b0,
    ENT_HDR = 1'b1
  } ent_kind_t;

  // one queued request: either a single result or a whole header burst
  typedef struct packed {
    ent_kind_t   kind;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        pay_hdr;
    logic [7:0]  data;
    logic        vld;
    logic        last;
    logic [1:0]  status;
  } rmp_ent_t;

  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                          input logic [15:0] seq,
                                          input logic [31:0] ts);
    logic [7:0] b;
    begin
      case (idx)
        4'd0:    b = RTP_BYTE0;
        4'd1:    b = RTP_BYTE1;
        4'd2:    b = seq[15:8];
        4'd3:    b = seq[7:0];
        4'd4:    b = ts[31:24];
        4'd5:    b = ts[23:16];
        4'd6:    b = ts[15:8];
        4'd7:    b = ts[7:0];
        4'd8:    b = RTP_SSRC[31:24];
        4'd9:    b = RTP_SSRC[23:16];
        4'd10:   b = RTP_SSRC[15:8];
        4'd11:   b = RTP_SSRC[7:0];
        4'd12:   b = MEDIA_HDR_BYTE;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

// ----- hw/rtl/rmp_front.sv -----
`timescale 1ns / 1ps
module rmp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [15:0]                   in_frame_length,
  input  logic [7:0]                    in_payload_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output rmp_pkg::rmp_ent_t             q_ent
);
  import rmp_pkg::*;

  codec_t      codec_r;
  logic        streaming_r;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [15:0] left_r, left_nxt;
  logic        open_r, open_nxt;

  logic [15:0] left_dec;
  logic [16:0] hlen;
  logic [16:0] total_len;
  logic [31:0] ts_incr;
  logic        use_rtp;

  assign in_ready = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r     <= CODEC_SBC;
      streaming_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODEC_KIND:   codec_r <= codec_t'(cfg_data[1:0]);
        REG_STREAMING_ON: streaming_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    use_rtp = (codec_r != CODEC_APTX);
    case (codec_r)
      CODEC_SBC: begin
        hlen = HLEN_RTP_PAY;
        ts_incr = TS_INCR_SBC;
      end
      CODEC_AAC: begin
        hlen = HLEN_RTP;
        ts_incr = TS_INCR_AAC;
      end
      CODEC_LC3: begin
        hlen = HLEN_RTP;
        ts_incr = TS_INCR_LC3;
      end
      default: begin
        hlen = '0;
        ts_incr = '0;
      end
    endcase
    total_len = hlen + {1'b0, in_frame_length};
    left_dec  = left_r - 16'd1;
  end

  always_comb begin
    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    left_nxt = left_r;
    open_nxt = open_r;
    q_push   = 1'b0;
    q_ent    = '0;
    q_ent.kind = ENT_ONE;
    if (in_valid && in_ready) begin
      if (in_command == CMD_PAYLOAD) begin
        // stray bytes with no open frame are dropped
        if (open_r) begin
          left_nxt     = left_dec;
          open_nxt     = (left_dec != 16'd0);
          q_push       = 1'b1;
          q_ent.data   = in_payload_byte;
          q_ent.vld    = 1'b1;
          q_ent.last   = (left_dec == 16'd0);
          q_ent.status = ST_OK;
        end
      end else begin
        open_nxt = 1'b0;
        left_nxt = '0;
        if (!streaming_r) begin
          q_push       = 1'b1;
          q_ent.status = ST_NOT_STREAMING;
        end else if (total_len > MAX_PACKET_LEN) begin
          q_push       = 1'b1;
          q_ent.status = ST_TOO_LONG;
        end else begin
          if (use_rtp) begin
            q_push        = 1'b1;
            q_ent.kind    = ENT_HDR;
            q_ent.seq     = seq_r;
            q_ent.ts      = ts_r;
            q_ent.pay_hdr = (codec_r == CODEC_SBC);
            q_ent.last    = (in_frame_length == 16'd0);
            seq_nxt       = seq_r + 16'd1;
            ts_nxt        = ts_r + ts_incr;
          end else if (in_frame_length == 16'd0) begin
            // empty frame without rtp: lone marker
            q_push     = 1'b1;
            q_ent.last = 1'b1;
          end
          if (in_frame_length != 16'd0) begin
            open_nxt = 1'b1;
            left_nxt = in_frame_length;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      left_r <= '0;
      open_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ----- hw/rtl/rmp_fifo.sv -----
`timescale 1ns / 1ps
module rmp_fifo #(
  parameter int DEPTH = rmp_pkg::RMP_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmp_pkg::rmp_ent_t push_ent,
  input  logic              pop,
  output rmp_pkg::rmp_ent_t head_ent,
  output logic              empty,
  output logic              full
);
  import rmp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rmp_ent_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);
  assign head_ent = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/rmp_back.sv -----
`timescale 1ns / 1ps
module rmp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rmp_pkg::rmp_ent_t head_ent,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_packet_last,
  output logic [1:0]        out_status
);
  import rmp_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  logic [HDR_IDX_W-1:0] last_idx;
  logic                 load;
  logic [7:0]           byte_r, byte_nxt;
  logic                 bvld_r, bvld_nxt;
  logic                 last_r, last_nxt;
  logic [1:0]           status_r, status_nxt;

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvld_r;
  assign out_packet_last = last_r;
  assign out_status      = status_r;

  assign last_idx = head_ent.pay_hdr ? HDR_LAST_PAY : HDR_LAST_RTP;
  // a request is queued and the output register is free or being emptied this cycle
  assign load = !q_empty && (!valid_r || out_ready);

  always_comb begin
    valid_nxt  = valid_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    byte_nxt   = byte_r;
    bvld_nxt   = bvld_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (head_ent.kind == ENT_HDR) begin
        byte_nxt   = hdr_byte(idx_r, head_ent.seq, head_ent.ts);
        bvld_nxt   = 1'b1;
        last_nxt   = head_ent.last && (idx_r == last_idx);
        status_nxt = ST_OK;
        if (idx_r == last_idx) begin
          q_pop   = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + HDR_IDX_W'(1);
        end
      end else begin
        byte_nxt   = head_ent.data;
        bvld_nxt   = head_ent.vld;
        last_nxt   = head_ent.last;
        status_nxt = head_ent.status;
        q_pop      = 1'b1;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvld_r   <= bvld_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

endmodule

// ----- hw/rtl/rtp_media_packetizer.sv -----
`timescale 1ns / 1ps
// media packetizer: wraps sbc, aac and lc3 frames into rtp packets, one byte per result
// input channel (in_valid/in_ready): a begin request carries the frame length,
//   a payload request carries one codec byte
// output channel (out_valid/out_ready): one packet byte, reject status or
//   empty-frame marker per result
// configuration port: cfg_we with cfg_index selects codec kind or streaming
//   enable; write only while the block is idle
// a request's first result passes through the request queue and then the output register
// throughput: one request per cycle while the queue has room; payload bytes stream
//   at one per cycle while out_ready is high, a header burst is 12 or 13 bytes at the
//   output register, and the request queue (FIFO_DEPTH entries) lets input go on meanwhile
// a stalled receiver holds the output register; requests queue behind it and
//   in_ready drops once the queue is full
// reset: sequence number, timestamp and open-frame state clear, the queue
//   empties, codec kind goes to sbc and streaming is off
module rtp_media_packetizer #(
  parameter int FIFO_DEPTH = rmp_pkg::RMP_FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [15:0]                    in_frame_length,
  input  logic [7:0]                     in_payload_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_packet_last,
  output logic [1:0]                     out_status
);
  import rmp_pkg::*;

  rmp_ent_t push_ent, head_ent;
  logic     q_push, q_pop, q_full, q_empty;

  rmp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_frame_length (in_frame_length),
    .in_payload_byte (in_payload_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ent           (push_ent)
  );

  rmp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .head_ent (head_ent),
    .empty    (q_empty),
    .full     (q_full)
  );

  rmp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_ent        (head_ent),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_packet_last (out_packet_last),
    .out_status      (out_status)
  );

endmodule

// ----- hw/rtl/rmp_checker.sv -----
`timescale 1ns / 1ps
module rmp_props (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_packet_last,
  input logic [1:0] out_status
);
  import rmp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_packet_last) && $stable(out_status))
    else $error("stalled result changed");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a reject carries no byte and closes no packet
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      !out_byte_valid && !out_packet_last && out_byte == 8'h00)
    else $error("reject status with packet content");

  // an ok result without a byte is only the empty-frame marker
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && !out_byte_valid |->
      out_packet_last && out_byte == 8'h00)
    else $error("ok result without byte is not a marker");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_NOT_STREAMING ||
      out_status == ST_TOO_LONG)
    else $error("undefined status code");

endmodule

bind rtp_media_packetizer rmp_props u_rmp_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_byte_valid  (out_byte_valid),
  .out_packet_last (out_packet_last),
  .out_status      (out_status)
);
